// ===== src/esd_pkg.sv =====
// Shared types and constants for the escape sequence decoder.
package esd_pkg;

    localparam int VALUE_W   = 13;
    localparam int ACCUM_W   = 12;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_LC_B  = 8'h62;
    localparam logic [7:0] CH_LC_E  = 8'h65;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_N  = 8'h6E;
    localparam logic [7:0] CH_LC_R  = 8'h72;
    localparam logic [7:0] CH_LC_S  = 8'h73;
    localparam logic [7:0] CH_LC_T  = 8'h74;
    localparam logic [7:0] CH_LC_X  = 8'h78;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_D0    = 8'h30;
    localparam logic [7:0] CH_D7    = 8'h37;
    localparam logic [7:0] CH_D9    = 8'h39;

    localparam logic [7:0] CASE_OFS  = 8'h20;
    localparam logic [7:0] CARET_OFS = 8'h40;

    localparam logic [VALUE_W-1:0] V_BS  = 13'd8;
    localparam logic [VALUE_W-1:0] V_FF  = 13'd12;
    localparam logic [VALUE_W-1:0] V_NL  = 13'd10;
    localparam logic [VALUE_W-1:0] V_CR  = 13'd13;
    localparam logic [VALUE_W-1:0] V_SP  = 13'd32;
    localparam logic [VALUE_W-1:0] V_TAB = 13'd9;
    localparam logic [VALUE_W-1:0] V_ESC = 13'd27;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_BSL   = 3'd1,
        MODE_CARET = 3'd2,
        MODE_HEX   = 3'd3,
        MODE_OCT   = 3'd4
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic [ACCUM_W-1:0] accum;
        logic [1:0]         cnt;
    } dec_state_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      esc;
        logic                      last;
    } res_t;

    typedef struct packed {
        logic [1:0] n;
        res_t       r0;
        res_t       r1;
    } dec_out_t;

endpackage

// ===== src/esd_decode.sv =====
// Combinational decode of one character against the current escape state.
module esd_decode (
    input  logic [7:0]          ch,
    input  esd_pkg::dec_state_t st,
    output esd_pkg::dec_state_t st_next,
    output esd_pkg::dec_out_t   res
);

    logic                        hex_mode;
    logic                        is_dig;
    logic [3:0]                  dig;
    logic [esd_pkg::ACCUM_W-1:0] acc_new;
    logic [1:0]                  cnt_new;
    logic [7:0]                  up;

    always_comb
    begin
        hex_mode = (st.mode == esd_pkg::MODE_HEX);
        dig      = 4'd0;
        is_dig   = 1'b0;
        if (hex_mode)
        begin
            if (ch inside {[esd_pkg::CH_D0:esd_pkg::CH_D9]})
            begin
                is_dig = 1'b1;
                dig    = 4'(ch - esd_pkg::CH_D0);
            end
            else if (ch inside {[esd_pkg::CH_LC_A:esd_pkg::CH_LC_F]})
            begin
                is_dig = 1'b1;
                dig    = 4'(ch - esd_pkg::CH_LC_A + 8'd10);
            end
            else if (ch inside {[esd_pkg::CH_UC_A:esd_pkg::CH_UC_F]})
            begin
                is_dig = 1'b1;
                dig    = 4'(ch - esd_pkg::CH_UC_A + 8'd10);
            end
        end
        else if (ch inside {[esd_pkg::CH_D0:esd_pkg::CH_D7]})
        begin
            is_dig = 1'b1;
            dig    = 4'(ch - esd_pkg::CH_D0);
        end
        if (hex_mode)
            acc_new = {st.accum[esd_pkg::ACCUM_W-5:0], dig};
        else
            acc_new = {st.accum[esd_pkg::ACCUM_W-4:0], dig[2:0]};
        cnt_new = st.cnt + 2'd1;
        up = (ch inside {[esd_pkg::CH_LC_A:esd_pkg::CH_LC_Z]}) ? ch - esd_pkg::CASE_OFS : ch;
    end

    always_comb
    begin
        st_next.mode  = esd_pkg::MODE_IDLE;
        st_next.accum = '0;
        st_next.cnt   = '0;
        res.n         = 2'd0;
        res.r0        = '0;
        res.r1        = '0;
        case (st.mode)
            esd_pkg::MODE_BSL:
            begin
                res.n      = 2'd1;
                res.r0.esc = 1'b1;
                case (ch)
                    esd_pkg::CH_NUL:  res.r0.value = {5'd0, esd_pkg::CH_BSL};
                    esd_pkg::CH_LC_B: res.r0.value = esd_pkg::V_BS;
                    esd_pkg::CH_LC_F: res.r0.value = esd_pkg::V_FF;
                    esd_pkg::CH_LC_N: res.r0.value = esd_pkg::V_NL;
                    esd_pkg::CH_LC_R: res.r0.value = esd_pkg::V_CR;
                    esd_pkg::CH_LC_S: res.r0.value = esd_pkg::V_SP;
                    esd_pkg::CH_LC_T: res.r0.value = esd_pkg::V_TAB;
                    esd_pkg::CH_LC_E: res.r0.value = esd_pkg::V_ESC;
                    esd_pkg::CH_CARET:
                    begin
                        res.n        = 2'd0;
                        st_next.mode = esd_pkg::MODE_CARET;
                    end
                    esd_pkg::CH_LC_X:
                    begin
                        res.n        = 2'd0;
                        st_next.mode = esd_pkg::MODE_HEX;
                    end
                    default:
                    begin
                        if (ch inside {[esd_pkg::CH_D0:esd_pkg::CH_D7]})
                        begin
                            res.n         = 2'd0;
                            st_next.mode  = esd_pkg::MODE_OCT;
                            st_next.accum = {9'd0, dig[2:0]};
                            st_next.cnt   = 2'd1;
                        end
                        else
                            res.r0.value = {5'd0, ch};
                    end
                endcase
            end
            esd_pkg::MODE_CARET:
            begin
                res.n        = 2'd1;
                res.r0.esc   = 1'b1;
                res.r0.value = {5'd0, up} - {5'd0, esd_pkg::CARET_OFS};
            end
            esd_pkg::MODE_HEX, esd_pkg::MODE_OCT:
            begin
                if (is_dig)
                begin
                    if (cnt_new == 2'd3)
                    begin
                        res.n        = 2'd1;
                        res.r0.esc   = 1'b1;
                        res.r0.value = {1'b0, acc_new};
                    end
                    else
                    begin
                        st_next.mode  = st.mode;
                        st_next.accum = acc_new;
                        st_next.cnt   = cnt_new;
                    end
                end
                else
                begin
                    res.n        = 2'd1;
                    res.r0.esc   = 1'b1;
                    res.r0.value = {1'b0, st.accum};
                    if (ch == esd_pkg::CH_BSL)
                        st_next.mode = esd_pkg::MODE_BSL;
                    else if (ch != esd_pkg::CH_NUL)
                    begin
                        res.n        = 2'd2;
                        res.r1.value = {5'd0, ch};
                    end
                end
            end
            default:
            begin
                if (ch == esd_pkg::CH_BSL)
                    st_next.mode = esd_pkg::MODE_BSL;
                else if (ch != esd_pkg::CH_NUL)
                begin
                    res.n        = 2'd1;
                    res.r0.value = {5'd0, ch};
                end
            end
        endcase
        res.r0.last = (res.n == 2'd1);
        res.r1.last = (res.n == 2'd2);
    end

endmodule

// ===== src/esd_fifo.sv =====
// Result queue: takes up to two results per cycle, hands out one per cycle while q_ready is high.
module esd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [1:0]    push_n,
    input  esd_pkg::res_t d0,
    input  esd_pkg::res_t d1,
    output logic          room2,
    output logic          q_valid,
    input  logic          q_ready,
    output esd_pkg::res_t q
);

    esd_pkg::res_t                mem [esd_pkg::Q_DEPTH];
    logic [esd_pkg::Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [esd_pkg::Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [esd_pkg::Q_CNT_W-1:0]  count_reg, count_next;
    logic                         pop;
    logic [esd_pkg::Q_PTR_W-1:0]  wr_ptr_p1;

    assign q_valid   = (count_reg != '0);
    assign pop       = q_valid && q_ready;
    assign room2     = (count_reg <= esd_pkg::Q_CNT_W'(esd_pkg::Q_DEPTH - 2));
    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + esd_pkg::Q_PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + esd_pkg::Q_PTR_W'(pop);
        count_next  = count_reg + esd_pkg::Q_CNT_W'(push_n) - esd_pkg::Q_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            mem[wr_ptr_reg] <= d0;
        if (push_n == 2'd2)
            mem[wr_ptr_p1] <= d1;
    end

    assign q = mem[rd_ptr_reg];

endmodule

// ===== src/escape_sequence_decoder_top.sv =====
// Top level of the escape sequence decoder: input register, decode, result queue.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------
//  in      | in_valid / in_ready  | ch[7:0]
//  out     | out_valid / out_ready| value[12:0] s, from_escape, last_of_item
//
// One item per cycle in while in_ready is high; one result per cycle out while
// out_ready is high, so an item that ends a digit run and gives two results hands
// them out one after the other. Throughput is set by the single read port of the
// four-entry result queue. An accepted item goes through the input register into
// the result queue. Reset returns the decoder to idle and empties the queue. A
// stalled output backs up into in_ready once the queue has under two free entries.
module escape_sequence_decoder_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        ch,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [esd_pkg::VALUE_W-1:0] value,
    output logic                              from_escape,
    output logic                              last_of_item
);

    logic                inv_reg;
    logic [7:0]          ch_reg;
    esd_pkg::dec_state_t st_reg, st_next;
    esd_pkg::dec_out_t   dec;
    logic                room2;
    logic                fire;
    esd_pkg::res_t       q;
    logic [1:0]          push_n;

    assign fire     = inv_reg && room2;
    assign in_ready = !inv_reg || fire;
    assign push_n   = fire ? dec.n : 2'd0;

    esd_decode u_decode (
        .ch      (ch_reg),
        .st      (st_reg),
        .st_next (st_next),
        .res     (dec)
    );

    esd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_n  (push_n),
        .d0      (dec.r0),
        .d1      (dec.r1),
        .room2   (room2),
        .q_valid (out_valid),
        .q_ready (out_ready),
        .q       (q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg      <= 1'b0;
            st_reg.mode  <= esd_pkg::MODE_IDLE;
            st_reg.accum <= '0;
            st_reg.cnt   <= '0;
        end
        else
        begin
            if (in_ready)
                inv_reg <= in_valid;
            if (fire)
                st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            ch_reg <= ch;
    end

    assign value        = q.value;
    assign from_escape  = q.esc;
    assign last_of_item = q.last;

endmodule
